// File: src/orc_pkg.sv
// orc_pkg: shared constants, types and the slot hash for the operation result cache
`timescale 1ns / 1ps

package orc_pkg;

  // table size must stay a power of two: the slot is then the low bits of the hash
  localparam int IDX_W      = 12;
  localparam int TABLE_SIZE = 1 << IDX_W;
  localparam int CNT_W      = IDX_W + 1;

  localparam int OP_W   = 7;
  localparam int ID_W   = 32;
  localparam int VAL_W  = 32;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 48;

  localparam logic [31:0]      HASH_SEED  = 32'd5381;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic OPC_LOOKUP = 1'b0;
  localparam logic OPC_INSERT = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] hash;
    logic [OP_W-1:0]  op_kind;
    logic [ID_W-1:0]  left_id;
    logic [ID_W-1:0]  right_id;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             clear_we;
    logic [IDX_W-1:0] clear_addr;
    logic             load_in;
    logic             read_entry;
    logic             commit;
  } ctl_cmd_t;

  // djb2 reduced to the slot width; the 31-bit mask has no effect below 32 bits
  function automatic logic [IDX_W-1:0] slot_hash(input logic [OP_W-1:0] op,
                                                 input logic [ID_W-1:0] a,
                                                 input logic [ID_W-1:0] b);
    logic [IDX_W-1:0] h;
    h = HASH_SEED[IDX_W-1:0];
    h = (h << 5) + h + IDX_W'(op);
    h = (h << 5) + h + IDX_W'(a);
    h = (h << 5) + h + IDX_W'(b);
    return h;
  endfunction

endpackage

// File: src/orc_ctrl.sv
// orc_ctrl: sequencer for the clearing pass, the two memory reads and write-back
`timescale 1ns / 1ps

module orc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output orc_pkg::ctl_cmd_t cmd_o
);

  localparam logic [1:0] S_CLEAR   = 2'd0;
  localparam logic [1:0] S_IDLE    = 2'd1;
  localparam logic [1:0] S_ENTRY   = 2'd2;
  localparam logic [1:0] S_RESOLVE = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [orc_pkg::IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic                      out_valid_q, out_valid_d;

  always_comb begin
    state_d        = state_q;
    clr_cnt_d      = clr_cnt_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.clear_addr = clr_cnt_q;
    out_valid_d    = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        clr_cnt_d      = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_ENTRY;
        end
      end
      S_ENTRY: begin
        cmd_o.read_entry = 1'b1;
        state_d          = S_RESOLVE;
      end
      S_RESOLVE: begin
        // hold the result back until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/orc_dp.sv
// orc_dp: hash, slot index memory, dense entry store, occupancy count and result register
`timescale 1ns / 1ps

module orc_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  orc_pkg::ctl_cmd_t                  cmd_i,
  input  logic                               opcode_i,
  input  logic [orc_pkg::OP_W-1:0]           op_kind_i,
  input  logic [orc_pkg::ID_W-1:0]           left_id_i,
  input  logic [orc_pkg::ID_W-1:0]           right_id_i,
  input  logic [orc_pkg::VAL_W-1:0]          store_value_i,
  output logic                               found_o,
  output logic [orc_pkg::VAL_W-1:0]          cached_value_o,
  output logic                               allocated_o,
  output logic [orc_pkg::CNT_W-1:0]          occupancy_o
);

  logic [orc_pkg::IDX_W-1:0] slot_mem [orc_pkg::TABLE_SIZE];
  orc_pkg::entry_t           entry_mem [orc_pkg::TABLE_SIZE];

  logic                      opcode_q;
  orc_pkg::entry_t           key_q;
  logic [orc_pkg::IDX_W-1:0] slot_q;
  orc_pkg::entry_t           entry_q;
  logic [orc_pkg::CNT_W-1:0] count_q, count_d;

  logic                      found_q, found_d;
  logic [orc_pkg::VAL_W-1:0] value_q, value_d;
  logic                      alloc_q, alloc_d;
  logic [orc_pkg::CNT_W-1:0] occ_q;

  logic [orc_pkg::IDX_W-1:0] hash_in;
  logic                      slot_valid;
  logic                      key_match;
  logic                      entry_we;
  logic [orc_pkg::IDX_W-1:0] entry_waddr;
  logic                      slot_we;
  logic [orc_pkg::IDX_W-1:0] slot_waddr;
  logic [orc_pkg::IDX_W-1:0] slot_wdata;

  assign hash_in = orc_pkg::slot_hash(op_kind_i, left_id_i, right_id_i);

  // an index at or past the count, or an entry owned by another slot, is stale
  assign slot_valid = ({1'b0, slot_q} < count_q) && (entry_q.hash == key_q.hash);
  assign key_match  = (entry_q.op_kind == key_q.op_kind) && (entry_q.left_id == key_q.left_id)
                   && (entry_q.right_id == key_q.right_id);

  always_comb begin
    count_d     = count_q;
    found_d     = 1'b0;
    value_d     = orc_pkg::MISS_VALUE;
    alloc_d     = 1'b0;
    entry_we    = 1'b0;
    entry_waddr = slot_q;
    slot_we     = cmd_i.clear_we;
    slot_waddr  = cmd_i.clear_addr;
    slot_wdata  = '0;
    if (cmd_i.commit) begin
      if (opcode_q == orc_pkg::OPC_LOOKUP) begin
        if (slot_valid && key_match) begin
          found_d = 1'b1;
          value_d = entry_q.value;
        end
      end else if (slot_valid) begin
        entry_we = 1'b1;
      end else if (!count_q[orc_pkg::IDX_W]) begin
        // fresh dense entry; dropped when the store is full
        entry_we    = 1'b1;
        entry_waddr = count_q[orc_pkg::IDX_W-1:0];
        slot_we     = 1'b1;
        slot_waddr  = key_q.hash;
        slot_wdata  = count_q[orc_pkg::IDX_W-1:0];
        count_d     = count_q + 1'b1;
        alloc_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (cmd_i.load_in) begin
      slot_q <= slot_mem[hash_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_mem[entry_waddr] <= key_q;
    end
    if (cmd_i.read_entry) begin
      entry_q <= entry_mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      opcode_q       <= opcode_i;
      key_q.hash     <= hash_in;
      key_q.op_kind  <= op_kind_i;
      key_q.left_id  <= left_id_i;
      key_q.right_id <= right_id_i;
      key_q.value    <= store_value_i;
    end
    if (cmd_i.commit) begin
      found_q <= found_d;
      value_q <= value_d;
      alloc_q <= alloc_d;
      occ_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign found_o        = found_q;
  assign cached_value_o = value_q;
  assign allocated_o    = alloc_q;
  assign occupancy_o    = occ_q;

endmodule

// File: src/operation_result_cache.sv
// timing: an accepted input beat goes through the slot index read, the entry store read and
//   the write-back into the output register; the write-back waits while an earlier result beat
//   still waits in the output register. A new input beat is taken only after the write-back of
//   the last; the reads and the write-back each use a single memory port
// reset: asynchronous, active low; afterwards a pass over every slot clears the slot
//   index memory, and no input beat is taken until it ends
`timescale 1ns / 1ps

module operation_result_cache (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [orc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // op_kind, left_id, right_id, store_value
  input  logic                               s_axis_tuser,  // opcode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [orc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // found, cached_value, allocated, occupancy
);

  orc_pkg::ctl_cmd_t         cmd;
  logic                      found;
  logic [orc_pkg::VAL_W-1:0] cached_value;
  logic                      allocated;
  logic [orc_pkg::CNT_W-1:0] occupancy;

  orc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  orc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (s_axis_tuser),
    .op_kind_i      (s_axis_tdata[6:0]),
    .left_id_i      (s_axis_tdata[38:7]),
    .right_id_i     (s_axis_tdata[70:39]),
    .store_value_i  (s_axis_tdata[102:71]),
    .found_o        (found),
    .cached_value_o (cached_value),
    .allocated_o    (allocated),
    .occupancy_o    (occupancy)
  );

  assign m_axis_tdata = {1'b0, occupancy, allocated, cached_value, found};

endmodule

// File: tb/sv/operation_result_cache_tb.sv
// operation_result_cache_tb: self-checking stream testbench for the operation result cache
`timescale 1ns / 1ps

module operation_result_cache_tb;

  typedef struct packed {
    logic                      opcode;
    logic [orc_pkg::OP_W-1:0]  op_kind;
    logic [orc_pkg::ID_W-1:0]  left_id;
    logic [orc_pkg::ID_W-1:0]  right_id;
    logic [orc_pkg::VAL_W-1:0] store_value;
  } cache_item_t;

  typedef struct packed {
    logic [orc_pkg::OP_W-1:0] op_kind;
    logic [orc_pkg::ID_W-1:0] left_id;
    logic [orc_pkg::ID_W-1:0] right_id;
  } memo_key_t;

  typedef struct packed {
    logic                      found;
    logic [orc_pkg::VAL_W-1:0] cached_value;
    logic                      allocated;
    logic [orc_pkg::CNT_W-1:0] occupancy;
  } cache_result_t;

  typedef struct {
    int unsigned               slot;
    logic [orc_pkg::OP_W-1:0]  op_kind;
    logic [orc_pkg::ID_W-1:0]  left_id;
    logic [orc_pkg::ID_W-1:0]  right_id;
    logic [orc_pkg::VAL_W-1:0] value;
  } memo_entry_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [orc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // op_kind, left_id, right_id, store_value
  logic                            s_axis_tuser  = 1'b0;  // opcode
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [orc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;  // found, cached_value, allocated, occupancy

  operation_result_cache i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the cache contents
  int unsigned   slot_ptr [orc_pkg::TABLE_SIZE];
  memo_entry_t   memo_store [orc_pkg::TABLE_SIZE];
  int unsigned   entry_count = 0;

  cache_item_t   pending_items [$];
  cache_result_t expected_results [$];
  memo_key_t     known_keys [$];
  cache_item_t   on_bus;

  int unsigned total_items    = 0;
  int unsigned accepted_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned lookup_hits    = 0;
  int unsigned lookup_misses  = 0;
  int unsigned fresh_allocs   = 0;
  int unsigned overwrites     = 0;
  int unsigned peak_occupancy = 0;

  function automatic cache_result_t predict_cache(cache_item_t it);
    logic [31:0]   h;
    int unsigned   slot;
    int unsigned   idx;
    bit            valid;
    bit            do_write;
    cache_result_t r;
    h = orc_pkg::HASH_SEED;
    h = (h << 5) + h + 32'(it.op_kind);
    h = (h << 5) + h + it.left_id;
    h = (h << 5) + h + it.right_id;
    slot  = (h & 32'h7FFF_FFFF) % orc_pkg::TABLE_SIZE;
    idx   = slot_ptr[slot];
    valid = (idx < entry_count) && (memo_store[idx].slot == slot);
    r.found        = 1'b0;
    r.cached_value = orc_pkg::MISS_VALUE;
    r.allocated    = 1'b0;
    if (it.opcode == orc_pkg::OPC_LOOKUP) begin
      if (valid && memo_store[idx].op_kind == it.op_kind &&
          memo_store[idx].left_id == it.left_id && memo_store[idx].right_id == it.right_id) begin
        r.found        = 1'b1;
        r.cached_value = memo_store[idx].value;
        lookup_hits++;
      end else begin
        lookup_misses++;
      end
    end else begin
      do_write = 1'b1;
      if (!valid) begin
        if (entry_count < orc_pkg::TABLE_SIZE) begin
          idx            = entry_count;
          slot_ptr[slot] = idx;
          entry_count++;
          r.allocated    = 1'b1;
          fresh_allocs++;
        end else begin
          // store full: insert is dropped
          do_write = 1'b0;
        end
      end else begin
        overwrites++;
      end
      if (do_write) begin
        memo_store[idx].slot     = slot;
        memo_store[idx].op_kind  = it.op_kind;
        memo_store[idx].left_id  = it.left_id;
        memo_store[idx].right_id = it.right_id;
        memo_store[idx].value    = it.store_value;
      end
    end
    r.occupancy = entry_count[orc_pkg::CNT_W-1:0];
    if (entry_count > peak_occupancy) peak_occupancy = entry_count;
    return r;
  endfunction

  function automatic void queue_item(logic opc, memo_key_t k, logic [orc_pkg::VAL_W-1:0] v);
    cache_item_t it;
    it.opcode      = opc;
    it.op_kind     = k.op_kind;
    it.left_id     = k.left_id;
    it.right_id    = k.right_id;
    it.store_value = v;
    pending_items = {pending_items, it};
    total_items++;
    if (opc == orc_pkg::OPC_INSERT) known_keys = {known_keys, k};
  endfunction

  function automatic memo_key_t random_key();
    memo_key_t   k;
    logic [31:0] kind;
    kind       = $urandom_range(0, 127);
    k.op_kind  = kind[orc_pkg::OP_W-1:0];
    k.left_id  = $urandom;
    k.right_id = $urandom;
    return k;
  endfunction

  // moving an id by a multiple of the table size keeps the slot but changes the key
  function automatic memo_key_t alias_key(memo_key_t k);
    memo_key_t a;
    a = k;
    if ($urandom_range(0, 1) == 0)
      a.right_id = k.right_id + ($urandom_range(1, 1023) << orc_pkg::IDX_W);
    else a.left_id = k.left_id + ($urandom_range(1, 1023) << orc_pkg::IDX_W);
    return a;
  endfunction

  function automatic memo_key_t pick_known();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  function automatic void queue_random(int unsigned count);
    int unsigned r;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (known_keys.size() == 0 || r < 30)
        queue_item(orc_pkg::OPC_INSERT, random_key(), $urandom);
      else if (r < 45) queue_item(orc_pkg::OPC_INSERT, pick_known(), $urandom);
      else if (r < 55) queue_item(orc_pkg::OPC_INSERT, alias_key(pick_known()), $urandom);
      else if (r < 85) queue_item(orc_pkg::OPC_LOOKUP, pick_known(), $urandom);
      else if (r < 95) queue_item(orc_pkg::OPC_LOOKUP, alias_key(pick_known()), $urandom);
      else queue_item(orc_pkg::OPC_LOOKUP, random_key(), $urandom);
    end
  endfunction

  // sender: bursts of beats with random gaps between them
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results = {expected_results, predict_cache(on_bus)};
        accepted_items++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          on_bus = pending_items.pop_front();
          s_axis_tdata  <= {1'b0, on_bus.store_value, on_bus.right_id, on_bus.left_id,
                            on_bus.op_kind};
          s_axis_tuser  <= on_bus.opcode;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready pattern switches at random between four modes, from always ready to mostly stalled
  int unsigned sink_mode = 0;
  int unsigned sink_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode = $urandom_range(0, 3);
        sink_left = $urandom_range(20, 200);
      end else begin
        sink_left--;
      end
      case (sink_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= ($urandom_range(0, 1) == 0);
        end
        2: begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          m_axis_tready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    end
  endfunction

  // monitor: compare every result beat with the oldest prediction
  always @(posedge clk_i) begin
    cache_result_t want;
    cache_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found        = m_axis_tdata[0];
      got.cached_value = m_axis_tdata[32:1];
      got.allocated    = m_axis_tdata[33];
      got.occupancy    = m_axis_tdata[46:34];
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result beat with nothing outstanding, data %0h", $realtime,
                   m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        check_field("found", 32'(want.found), 32'(got.found));
        check_field("cached_value", want.cached_value, got.cached_value);
        check_field("allocated", 32'(want.allocated), 32'(got.allocated));
        check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
      end
    end
  end

  initial begin
    memo_key_t k1;
    memo_key_t k1_alias;
    memo_key_t k2;
    memo_key_t kmax;
    memo_key_t kmin;
    int unsigned drain_cycles;

    k1       = '{op_kind: 7'd5, left_id: 32'd1, right_id: 32'd2};
    k1_alias = '{op_kind: 7'd5, left_id: 32'd1, right_id: 32'd2 + (1 << orc_pkg::IDX_W)};
    k2       = '{op_kind: 7'd9, left_id: 32'hDEAD_BEEF, right_id: 32'h1234_5678};
    kmax     = '{op_kind: 7'h7F, left_id: 32'hFFFF_FFFF, right_id: 32'hFFFF_FFFF};
    kmin     = '0;

    // directed: empty table, stale slots, collisions, overwrites, field extremes
    queue_item(orc_pkg::OPC_LOOKUP, k1, 32'hFFFF_FFFF);
    queue_item(orc_pkg::OPC_LOOKUP, kmin, 32'h0);
    queue_item(orc_pkg::OPC_INSERT, k1, 32'h1111_1111);
    queue_item(orc_pkg::OPC_LOOKUP, k1, 32'h0);
    queue_item(orc_pkg::OPC_LOOKUP, k2, 32'h0);
    queue_item(orc_pkg::OPC_INSERT, k2, 32'h2222_2222);
    queue_item(orc_pkg::OPC_INSERT, k1_alias, 32'h3333_3333);
    queue_item(orc_pkg::OPC_LOOKUP, k1, 32'h0);
    queue_item(orc_pkg::OPC_LOOKUP, k1_alias, 32'h0);
    queue_item(orc_pkg::OPC_INSERT, k1_alias, 32'h4444_4444);
    queue_item(orc_pkg::OPC_LOOKUP, k1_alias, 32'h0);
    queue_item(orc_pkg::OPC_INSERT, kmax, 32'hFFFF_FFFF);
    queue_item(orc_pkg::OPC_LOOKUP, kmax, 32'h0);
    queue_item(orc_pkg::OPC_INSERT, kmin, 32'h0);
    queue_item(orc_pkg::OPC_LOOKUP, kmin, 32'hFFFF_FFFF);
    queue_item(orc_pkg::OPC_LOOKUP,
               '{op_kind: 7'd5, left_id: 32'd1 + (1 << orc_pkg::IDX_W), right_id: 32'd2},
               32'h0);
    queue_item(orc_pkg::OPC_INSERT, '{op_kind: 7'd6, left_id: 32'd1, right_id: 32'd2},
               32'hA5A5_A5A5);
    queue_item(orc_pkg::OPC_LOOKUP, '{op_kind: 7'd6, left_id: 32'd1, right_id: 32'd2}, 32'h0);
    queue_item(orc_pkg::OPC_LOOKUP, k2, 32'h5A5A_5A5A);

    queue_random(700);
    queue_random(800);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_items == total_items);
    while (expected_results.size() != 0) @(posedge clk_i);
    drain_cycles = 0;
    while (drain_cycles < 20) begin
      @(posedge clk_i);
      drain_cycles++;
    end

    $display("%0d beats checked: %0d lookup hits, %0d lookup misses", accepted_items,
             lookup_hits, lookup_misses);
    $display("%0d fresh entries, %0d overwrites, peak occupancy %0d, %0d mismatches",
             fresh_allocs, overwrites, peak_occupancy, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("operation_result_cache verification clean");
    end else begin
      $display("operation_result_cache verification failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout with %0d of %0d beats accepted", accepted_items, total_items);
    $display("operation_result_cache verification failed");
    $finish;
  end

endmodule

// File: sim.f
src/orc_pkg.sv
src/orc_ctrl.sv
src/orc_dp.sv
src/operation_result_cache.sv
tb/sv/operation_result_cache_tb.sv
